[rtl/cpe_pkg.sv]
// cpe_pkg: shared constants, types and helper function of the cpm phase state encoder
// depends on nothing; used by every module of the encoder by scoped names
`timescale 1ns / 1ps

package cpe_pkg;

	// structural limits
	localparam int MAX_MEMORY_LENGTH = 8;
	localparam int MAX_SYMBOL_BITS   = 4;
	localparam int MAX_PHASE_BITS    = 6;

	// phase field plus the stored symbols, and the waveform index with the new symbol on top
	localparam int STATE_BITS = MAX_PHASE_BITS + MAX_SYMBOL_BITS * (MAX_MEMORY_LENGTH - 1);
	localparam int WAVE_BITS  = STATE_BITS + MAX_SYMBOL_BITS;
	localparam int SHIFT_W    = $clog2(WAVE_BITS + 1);

	// configuration register field widths
	localparam int P_W        = 6;
	localparam int PB_W       = 3;
	localparam int NB_W       = 3;
	localparam int MEM_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// largest phase plus stored symbol sum seen by the remainder unit
	localparam int ACC_MAX = (2 ** MAX_PHASE_BITS - 1)
		+ (MAX_MEMORY_LENGTH - 1) * (2 ** MAX_SYMBOL_BITS - 1);
	localparam int ACC_W   = $clog2(ACC_MAX + 1);

	// remainder unit: dividend bits retired per cycle and cycles per remainder
	localparam int MOD_STEPS  = 4;
	localparam int MOD_CYCLES = (ACC_W + MOD_STEPS - 1) / MOD_STEPS;
	localparam int DVD_W      = MOD_CYCLES * MOD_STEPS;
	localparam int CNT_W      = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

	// opcodes
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_TAIL   = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_MODULUS,
		CFG_PHASE_BITS,
		CFG_BITS_PER_SYMBOL,
		CFG_MEMORY_LENGTH
	} cfg_idx_t;

	// effective configuration after clamping
	typedef struct packed {
		logic [P_W-1:0]             modulus;
		logic [PB_W-1:0]            phase_bits;
		logic [NB_W-1:0]            sym_bits;
		logic [MEM_W-1:0]           mem_len;
		logic [SHIFT_W-1:0]         width;
		logic [MAX_PHASE_BITS-1:0]  pmask;
		logic [MAX_SYMBOL_BITS-1:0] smask;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sum;
		logic step;
		logic sym;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_tail;
		logic out_free;
	} status_t;

	function automatic logic [WAVE_BITS-1:0] low_mask(input logic [SHIFT_W-1:0] n);
		return ~({WAVE_BITS{1'b1}} << n);
	endfunction

endpackage

[rtl/cpe_config.sv]
// cpe_config: configuration registers of the encoder and their clamped effective values
// depends on cpe_pkg
`timescale 1ns / 1ps

module cpe_config (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	output cpe_pkg::cfg_t                   cfg
);

	logic [cpe_pkg::P_W-1:0]   modulus_q;
	logic [cpe_pkg::PB_W-1:0]  phase_bits_q;
	logic [cpe_pkg::NB_W-1:0]  sym_bits_q;
	logic [cpe_pkg::MEM_W-1:0] mem_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= cpe_pkg::P_W'(2);
			phase_bits_q <= cpe_pkg::PB_W'(1);
			sym_bits_q   <= cpe_pkg::NB_W'(1);
			mem_len_q    <= cpe_pkg::MEM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cpe_pkg::cfg_idx_t'(cfg_index))
				cpe_pkg::CFG_PHASE_MODULUS:   modulus_q    <= cfg_data[cpe_pkg::P_W-1:0];
				cpe_pkg::CFG_PHASE_BITS:      phase_bits_q <= cfg_data[cpe_pkg::PB_W-1:0];
				cpe_pkg::CFG_BITS_PER_SYMBOL: sym_bits_q   <= cfg_data[cpe_pkg::NB_W-1:0];
				cpe_pkg::CFG_MEMORY_LENGTH:   mem_len_q    <= cfg_data[cpe_pkg::MEM_W-1:0];
				default: ;
			endcase
		end
	end

	logic [cpe_pkg::PB_W-1:0]    pb_c;
	logic [cpe_pkg::NB_W-1:0]    nb_c;
	logic [cpe_pkg::MEM_W-1:0]   mem_c;
	logic [cpe_pkg::SHIFT_W-1:0] width_c;
	logic [cpe_pkg::WAVE_BITS-1:0] pmask_c;
	logic [cpe_pkg::WAVE_BITS-1:0] smask_c;

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (phase_bits_q == '0) pb_c = cpe_pkg::PB_W'(1);
		else if (phase_bits_q > cpe_pkg::PB_W'(cpe_pkg::MAX_PHASE_BITS))
			pb_c = cpe_pkg::PB_W'(cpe_pkg::MAX_PHASE_BITS);
		else pb_c = phase_bits_q;

		if (sym_bits_q == '0) nb_c = cpe_pkg::NB_W'(1);
		else if (sym_bits_q > cpe_pkg::NB_W'(cpe_pkg::MAX_SYMBOL_BITS))
			nb_c = cpe_pkg::NB_W'(cpe_pkg::MAX_SYMBOL_BITS);
		else nb_c = sym_bits_q;

		if (mem_len_q == '0) mem_c = cpe_pkg::MEM_W'(1);
		else if (mem_len_q > cpe_pkg::MEM_W'(cpe_pkg::MAX_MEMORY_LENGTH))
			mem_c = cpe_pkg::MEM_W'(cpe_pkg::MAX_MEMORY_LENGTH);
		else mem_c = mem_len_q;

		width_c = cpe_pkg::SHIFT_W'(pb_c)
			+ cpe_pkg::SHIFT_W'(nb_c) * cpe_pkg::SHIFT_W'(mem_c - cpe_pkg::MEM_W'(1));
		pmask_c = cpe_pkg::low_mask(cpe_pkg::SHIFT_W'(pb_c));
		smask_c = cpe_pkg::low_mask(cpe_pkg::SHIFT_W'(nb_c));
	end

	assign cfg.modulus    = (modulus_q == '0) ? cpe_pkg::P_W'(1) : modulus_q;
	assign cfg.phase_bits = pb_c;
	assign cfg.sym_bits   = nb_c;
	assign cfg.mem_len    = mem_c;
	assign cfg.width      = width_c;
	assign cfg.pmask      = pmask_c[cpe_pkg::MAX_PHASE_BITS-1:0];
	assign cfg.smask      = smask_c[cpe_pkg::MAX_SYMBOL_BITS-1:0];

endmodule

[rtl/cpe_mod_unit.sv]
// cpe_mod_unit: iterative restoring remainder, a few dividend bits per cycle
// depends on cpe_pkg
`timescale 1ns / 1ps

module cpe_mod_unit (
	input  logic                        clk,
	input  logic                        start,
	input  logic                        step,
	input  logic [cpe_pkg::ACC_W-1:0]   dividend,
	input  logic [cpe_pkg::P_W-1:0]     divisor,
	output logic [cpe_pkg::P_W-1:0]     remainder
);

	logic [cpe_pkg::DVD_W-1:0] dvd_q;
	logic [cpe_pkg::P_W-1:0]   rem_q;
	logic [cpe_pkg::DVD_W-1:0] dvd_c;
	logic [cpe_pkg::P_W-1:0]   rem_c;

	// divisor is at least one, so the partial remainder stays below it
	always_comb begin
		logic [cpe_pkg::P_W:0] t;
		dvd_c = dvd_q;
		rem_c = rem_q;
		for (int k = 0; k < cpe_pkg::MOD_STEPS; k++) begin
			t = {rem_c, dvd_c[cpe_pkg::DVD_W-1]};
			dvd_c = dvd_c << 1;
			if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
			rem_c = t[cpe_pkg::P_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= cpe_pkg::DVD_W'(dividend);
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= dvd_c;
			rem_q <= rem_c;
		end
	end

	assign remainder = rem_q;

endmodule

[rtl/cpe_datapath.sv]
// cpe_datapath: phase and history state, tail symbol, waveform index and output register
// depends on cpe_pkg and cpe_mod_unit
`timescale 1ns / 1ps

module cpe_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpe_pkg::cfg_t                         cfg,
	input  cpe_pkg::cmd_t                         cmd,
	output cpe_pkg::status_t                      status,
	input  logic                                  opcode,
	input  logic [cpe_pkg::MAX_SYMBOL_BITS-1:0]   symbol,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cpe_pkg::WAVE_BITS-1:0]         waveform_index,
	output logic [cpe_pkg::MAX_SYMBOL_BITS-1:0]   symbol_used
);

	logic [cpe_pkg::STATE_BITS-1:0]      state_q;
	logic [cpe_pkg::STATE_BITS-1:0]      item_st_q;
	logic                                op_q;
	logic [cpe_pkg::MAX_SYMBOL_BITS-1:0] sym_in_q;
	logic [cpe_pkg::WAVE_BITS-1:0]       word_q;
	logic [cpe_pkg::MAX_SYMBOL_BITS-1:0] sym_q;
	logic                                out_valid_q;
	logic [cpe_pkg::WAVE_BITS-1:0]       waveform_index_q;
	logic [cpe_pkg::MAX_SYMBOL_BITS-1:0] symbol_used_q;

	logic [cpe_pkg::MAX_PHASE_BITS-1:0]  v_c;
	logic [cpe_pkg::STATE_BITS-1:0]      hist_c;
	logic [cpe_pkg::ACC_W-1:0]           sum_c;
	logic [cpe_pkg::P_W-1:0]             rem;
	logic [cpe_pkg::P_W-1:0]             tail_c;
	logic [cpe_pkg::MAX_SYMBOL_BITS-1:0] sym_new_c;
	logic [cpe_pkg::WAVE_BITS-1:0]       word_c;
	logic [cpe_pkg::MAX_SYMBOL_BITS-1:0] oldest_c;
	logic [cpe_pkg::ACC_W-1:0]           vsum_c;
	logic [cpe_pkg::ACC_W-1:0]           mod_in_c;
	logic [cpe_pkg::MAX_PHASE_BITS-1:0]  v_new_c;
	logic [cpe_pkg::STATE_BITS-1:0]      next_st_c;

	assign v_c    = item_st_q[cpe_pkg::MAX_PHASE_BITS-1:0] & cfg.pmask;
	assign hist_c = item_st_q >> cfg.phase_bits;

	// phase plus all stored symbols
	always_comb begin
		sum_c = cpe_pkg::ACC_W'(v_c);
		for (int i = 0; i < cpe_pkg::MAX_MEMORY_LENGTH - 1; i++) begin
			if (cpe_pkg::MEM_W'(i + 1) < cfg.mem_len)
				sum_c = sum_c + cpe_pkg::ACC_W'((hist_c
					>> (cpe_pkg::SHIFT_W'(i) * cpe_pkg::SHIFT_W'(cfg.sym_bits)))
					& cpe_pkg::STATE_BITS'(cfg.smask));
		end
	end

	// symbol that returns the phase to zero
	assign tail_c = (rem == '0) ? '0 : cfg.modulus - rem;

	assign sym_new_c = ((op_q == cpe_pkg::OP_TAIL)
		? cpe_pkg::MAX_SYMBOL_BITS'(tail_c) : sym_in_q) & cfg.smask;
	assign word_c    = cpe_pkg::WAVE_BITS'(item_st_q)
		| (cpe_pkg::WAVE_BITS'(sym_new_c) << cfg.width);
	assign oldest_c  = cpe_pkg::MAX_SYMBOL_BITS'((word_c >> cfg.phase_bits)
		& cpe_pkg::WAVE_BITS'(cfg.smask));
	assign vsum_c    = cpe_pkg::ACC_W'(v_c) + cpe_pkg::ACC_W'(oldest_c);
	assign mod_in_c  = cmd.sum ? sum_c : vsum_c;

	cpe_mod_unit u_mod (
		.clk       (clk),
		.start     (cmd.sum | cmd.sym),
		.step      (cmd.step),
		.dividend  (mod_in_c),
		.divisor   (cfg.modulus),
		.remainder (rem)
	);

	// drop the oldest symbol, put the new phase underneath
	assign v_new_c   = cpe_pkg::MAX_PHASE_BITS'(rem) & cfg.pmask;
	assign next_st_c = cpe_pkg::STATE_BITS'(((((word_q
		>> (cpe_pkg::SHIFT_W'(cfg.phase_bits) + cpe_pkg::SHIFT_W'(cfg.sym_bits)))
		<< cfg.phase_bits) | cpe_pkg::WAVE_BITS'(v_new_c))
		& cpe_pkg::low_mask(cfg.width)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) state_q <= next_st_c;
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_st_q <= restart ? '0
				: state_q & cpe_pkg::STATE_BITS'(cpe_pkg::low_mask(cfg.width));
			op_q      <= opcode;
			sym_in_q  <= symbol;
		end
		if (cmd.sym) begin
			word_q <= word_c;
			sym_q  <= sym_new_c;
		end
		if (cmd.fin) begin
			waveform_index_q <= word_q;
			symbol_used_q    <= sym_q;
		end
	end

	assign status.in_tail  = (opcode == cpe_pkg::OP_TAIL);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign waveform_index = waveform_index_q;
	assign symbol_used    = symbol_used_q;

endmodule

[rtl/cpe_ctrl.sv]
// cpe_ctrl: controller state machine sequencing sum, remainder and write-back per item
// depends on cpe_pkg
`timescale 1ns / 1ps

module cpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpe_pkg::status_t  status,
	output cpe_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_TMOD,
		S_SYM,
		S_VMOD,
		S_FIN
	} state_t;

	state_t                   state_q;
	logic [cpe_pkg::CNT_W-1:0] cnt_q;
	logic                     in_stall_q;
	logic                     accept;
	logic                     mod_last;

	assign accept   = in_valid && !in_stall_q;
	assign mod_last = (cnt_q == cpe_pkg::CNT_W'(cpe_pkg::MOD_CYCLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_stall_q <= 1'b1;
						state_q    <= status.in_tail ? S_SUM : S_SYM;
					end
				end
				S_SUM: begin
					cnt_q   <= '0;
					state_q <= S_TMOD;
				end
				S_TMOD: begin
					cnt_q <= cnt_q + cpe_pkg::CNT_W'(1);
					if (mod_last) state_q <= S_SYM;
				end
				S_SYM: begin
					cnt_q   <= '0;
					state_q <= S_VMOD;
				end
				S_VMOD: begin
					cnt_q <= cnt_q + cpe_pkg::CNT_W'(1);
					if (mod_last) state_q <= S_FIN;
				end
				S_FIN: begin
					if (status.out_free) begin
						in_stall_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					in_stall_q <= 1'b0;
					state_q    <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = in_stall_q;
	assign cmd.load = accept;
	assign cmd.sum  = (state_q == S_SUM);
	assign cmd.step = (state_q == S_TMOD) || (state_q == S_VMOD);
	assign cmd.sym  = (state_q == S_SYM);
	assign cmd.fin  = (state_q == S_FIN) && status.out_free;

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> ((state_q == S_IDLE) == !in_stall_q))
		else $error("input ready outside idle state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item did not start processing");

	a_fin_waits_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !status.out_free) |=> (state_q == S_FIN))
		else $error("result written back while output register busy");

	a_tail_goes_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status.in_tail) |=> (state_q == S_SUM))
		else $error("tail item skipped the history sum");

endmodule

[rtl/cpm_phase_state_encoder_unit.sv]
// waveform_index is registered at write-back after the symbol and phase remainder steps
//   (a tail item runs the history sum and tail remainder first); the remainder unit
//   (4 dividend bits a cycle) runs once per item, twice for a tail, one item at a time
// reset: arst_n clears the phase and history state, the controller and the output valid;
//   configuration returns to modulus 2, phase bits 1, symbol bits 1, memory length 1
`timescale 1ns / 1ps

module cpm_phase_state_encoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input item channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [cpe_pkg::MAX_SYMBOL_BITS-1:0]   symbol,
	input  logic                                  restart,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cpe_pkg::WAVE_BITS-1:0]         waveform_index,
	output logic [cpe_pkg::MAX_SYMBOL_BITS-1:0]   symbol_used,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cpe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cpe_pkg::CFG_DATA_W-1:0]        cfg_data
);

	cpe_pkg::cfg_t    cfg;
	cpe_pkg::cmd_t    cmd;
	cpe_pkg::status_t status;

	// register file; always ready, writes are expected only while the encoder is idle
	cpe_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: idle -> (sum -> tail remainder) -> symbol -> phase remainder -> write-back
	// the write-back step waits while the previous result is still held in the output
	// register, so a new item can be taken as soon as its predecessor is parked there
	cpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// state word, symbol select, waveform packing, shared remainder unit and the
	// output register that holds a result until its transfer
	cpe_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.symbol         (symbol),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.waveform_index (waveform_index),
		.symbol_used    (symbol_used)
	);

endmodule
